>>> src/turnout_coil_pulse_driver_assert.svh
// Assertion macros shared by the turnout coil pulse driver modules.
// Expects clk_i and rst_ni in the scope of use; no other dependencies.
`ifndef TURNOUT_COIL_PULSE_DRIVER_ASSERT_SVH
`define TURNOUT_COIL_PULSE_DRIVER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock, masked while reset is asserted
`define TCPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check a property on every clock, reset included
`define TCPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define TCPD_ASSERT(lbl, prop, msg)
`define TCPD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> src/tcpd_pkg.sv
// Package for the turnout coil pulse driver: word types, constants, codes.
// No dependencies.
package tcpd_pkg;

  localparam int unsigned AddrW    = 9;
  localparam int unsigned CoilW    = 3;
  localparam int unsigned TurnoutW = 2;
  localparam int unsigned PulseW   = 8;
  localparam int unsigned NumPairs = 4;
  localparam int unsigned NumCoils = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 9;

  localparam logic [AddrW-1:0] BroadcastAddr = 9'd511;
  localparam logic [CoilW-1:0] EstopCoil     = 3'd3;

  // Item kinds
  typedef enum logic [1:0] {
    ACT_PACKET = 2'd0,
    ACT_BUTTON = 2'd1,
    ACT_TICK   = 2'd2
  } tcpd_action_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_OWN_ADDRESS  = 3'd0,
    CFG_PULSE_TIME_0 = 3'd1,
    CFG_PULSE_TIME_1 = 3'd2,
    CFG_PULSE_TIME_2 = 3'd3,
    CFG_PULSE_TIME_3 = 3'd4
  } tcpd_cfg_e;

  typedef struct packed {
    logic [1:0]          action;
    logic [AddrW-1:0]    packet_address;
    logic [CoilW-1:0]    coil_index;
    logic                turn_on;
    logic [TurnoutW-1:0] button_turnout;
  } tcpd_in_t;

  typedef struct packed {
    logic [NumCoils-1:0] output_levels;
    logic                confirm_flash;
  } tcpd_out_t;

endpackage

>>> src/tcpd_skid.sv
// Two-entry output buffer (result register plus skid register) for result words.
// Depends on tcpd_pkg and turnout_coil_pulse_driver_assert.svh.
`include "turnout_coil_pulse_driver_assert.svh"

module tcpd_skid import tcpd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_stall_o,
  input  tcpd_out_t push_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output tcpd_out_t out_word_o
);

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  tcpd_out_t out_word_q, out_word_d;
  tcpd_out_t skid_word_q, skid_word_d;
  logic      push, take;

  // Stall only once the skid register holds a word
  assign push_stall_o = skid_valid_q;
  assign push = push_valid_i & ~skid_valid_q;
  assign take = out_valid_q & ~out_stall_i;

  // Advance words: skid feeds the result register before any new push
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_word_d   = out_word_q;
    skid_word_d  = skid_word_q;
    if (push) begin
      if (!out_valid_q || take) begin
        out_word_d  = push_word_i;
        out_valid_d = 1'b1;
      end else begin
        skid_word_d  = push_word_i;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      if (skid_valid_q) begin
        out_word_d   = skid_word_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q  <= out_word_d;
    skid_word_q <= skid_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `TCPD_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_q || out_valid_q, "skid word without result word")
  `TCPD_ASSERT(a_skid_held, skid_valid_q && out_stall_i |=> skid_valid_q, "skid word lost while stalled")

endmodule

>>> src/turnout_coil_pulse_driver.sv
// Turnout coil pulse driver: one result word per input word, registered in the output buffer on acceptance.
// Throughput is one word per cycle while the buffer raises no stall; the state update sets the figure,
// and a two-entry output buffer keeps taking words while one result waits.
// Stall rises only when both output entries are full.
// Asynchronous active-low reset clears coil levels, pulse counters, turnout
// positions, configuration registers and the output buffer.
`include "turnout_coil_pulse_driver_assert.svh"

module turnout_coil_pulse_driver import tcpd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tcpd_in_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tcpd_out_t           out_word_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [AddrW-1:0]    own_addr_q;
  logic [PulseW-1:0]   pulse_time_q [NumPairs];
  logic [NumCoils-1:0] levels_q, levels_d;
  logic [PulseW-1:0]   cnt_q [NumPairs];
  logic [PulseW-1:0]   cnt_d [NumPairs];
  logic [NumPairs-1:0] pos_q, pos_d;

  logic                in_acc;
  logic                pos_tgl;
  logic [AddrW-1:0]    cmd_addr;
  logic [CoilW-1:0]    cmd_coil;
  logic [1:0]          cmd_pair;
  logic                cmd_hit, cmd_estop;
  logic                flash, estop;
  tcpd_out_t           res_word;
  logic                buf_stall;

  assign in_acc     = in_valid_i & ~buf_stall;
  assign in_stall_o = buf_stall;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= '0;
      for (int p = 0; p < NumPairs; p++) begin
        pulse_time_q[p] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_OWN_ADDRESS:  own_addr_q      <= cfg_data_i[AddrW-1:0];
        CFG_PULSE_TIME_0: pulse_time_q[0] <= cfg_data_i[PulseW-1:0];
        CFG_PULSE_TIME_1: pulse_time_q[1] <= cfg_data_i[PulseW-1:0];
        CFG_PULSE_TIME_2: pulse_time_q[2] <= cfg_data_i[PulseW-1:0];
        CFG_PULSE_TIME_3: pulse_time_q[3] <= cfg_data_i[PulseW-1:0];
        default: ;
      endcase
    end
  end

  // Resolve the command: a button press acts as a packet to our own address
  always_comb begin
    pos_tgl = in_word_i.turn_on ? ~pos_q[in_word_i.button_turnout]
                                : pos_q[in_word_i.button_turnout];
    if (in_word_i.action == ACT_BUTTON) begin
      cmd_addr = own_addr_q;
      cmd_coil = {in_word_i.button_turnout, pos_tgl};
    end else begin
      cmd_addr = in_word_i.packet_address;
      cmd_coil = in_word_i.coil_index;
    end
    cmd_pair  = cmd_coil[2:1];
    cmd_hit   = (cmd_addr == own_addr_q) || (cmd_addr == BroadcastAddr);
    cmd_estop = (cmd_addr == BroadcastAddr) && (cmd_coil == EstopCoil);
  end

  // Compute next coil levels, counters and positions
  always_comb begin
    levels_d = levels_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    flash    = 1'b0;
    estop    = 1'b0;
    case (in_word_i.action)
      ACT_PACKET, ACT_BUTTON: begin
        if (in_word_i.action == ACT_BUTTON) begin
          pos_d[in_word_i.button_turnout] = pos_tgl;
        end
        if (cmd_hit) begin
          if (cmd_estop) begin
            levels_d = '0;
            for (int p = 0; p < NumPairs; p++) begin
              cnt_d[p] = '0;
            end
            flash = 1'b1;
            estop = 1'b1;
          end else if (in_word_i.turn_on) begin
            levels_d[cmd_coil ^ 3'd1] = 1'b0;
            levels_d[cmd_coil]        = 1'b1;
            cnt_d[cmd_pair]           = pulse_time_q[cmd_pair];
            flash                     = 1'b1;
          end else if (pulse_time_q[cmd_pair] == '0) begin
            levels_d[cmd_coil] = 1'b0;
            flash              = 1'b1;
          end
        end
      end
      ACT_TICK: begin
        // Count down running pulses; drop the pair when one runs out
        for (int p = 0; p < NumPairs; p++) begin
          if (cnt_q[p] != '0) begin
            cnt_d[p] = cnt_q[p] - 8'd1;
            if (cnt_q[p] == 8'd1) begin
              levels_d[2*p +: 2] = 2'b00;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Hold state, update on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= '0;
      pos_q    <= '0;
      for (int p = 0; p < NumPairs; p++) begin
        cnt_q[p] <= '0;
      end
    end else if (in_acc) begin
      levels_q <= levels_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
    end
  end

  assign res_word.output_levels = levels_d;
  assign res_word.confirm_flash = flash;

  tcpd_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_stall_o (buf_stall),
    .push_word_i  (res_word),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o)
  );

  `TCPD_ASSERT_ALWAYS(a_pair_exclusive, ((levels_q & (levels_q >> 1)) & 8'h55) == 8'h00, "both coils of a pair on")
  `TCPD_ASSERT(a_estop_clears, in_acc && estop |=> levels_q == 8'h00, "outputs on after emergency stop")

endmodule

>>> test/tb_turnout_coil_pulse_driver.sv
// Self-checking bench for turnout_coil_pulse_driver: random and directed words
// against an in-bench coil/pulse predictor. Depends on tcpd_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_turnout_coil_pulse_driver;
  import tcpd_pkg::*;

  localparam logic [1:0] ActUnused  = 2'd3;
  localparam int         QuietLimit = 2000;
  localparam int         ReportMax  = 10;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  tcpd_in_t            in_word_i;
  logic                out_valid_o;
  logic                out_stall_i;
  tcpd_out_t           out_word_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Predictor copy of configuration and coil state
  logic [AddrW-1:0]  own_addr;
  logic [PulseW-1:0] pulse_len [NumPairs];
  logic [NumCoils-1:0] coil_lv;
  logic [PulseW-1:0] pulse_left [NumPairs];
  logic              lever_pos [NumPairs];

  tcpd_in_t  cmd_backlog[$];
  tcpd_out_t coil_report_due[$];

  logic word_taken;
  logic calm;
  int   send_gap;
  int   stall_left;
  int   quiet_cycles;
  int   fail_count;

  turnout_coil_pulse_driver u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Apply one command to the predicted coils; return the flash request
  function automatic logic run_command(logic [AddrW-1:0] addr, logic [CoilW-1:0] coil,
                                       logic on);
    logic [1:0] pair;
    pair = coil[2:1];
    if (addr != own_addr && addr != BroadcastAddr) return 1'b0;
    if (addr == BroadcastAddr && coil == EstopCoil) begin
      coil_lv = '0;
      for (int p = 0; p < NumPairs; p++) pulse_left[p] = '0;
      return 1'b1;
    end
    if (on) begin
      coil_lv[coil ^ 3'd1] = 1'b0;
      coil_lv[coil]        = 1'b1;
      pulse_left[pair]     = pulse_len[pair];
      return 1'b1;
    end
    // Release only takes effect on pairs without auto-off
    if (pulse_len[pair] == '0) begin
      coil_lv[coil] = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Predict the output word caused by one accepted input word
  function automatic tcpd_out_t drive_coils(tcpd_in_t w);
    tcpd_out_t  r;
    logic       flash;
    logic [1:0] t;
    flash = 1'b0;
    t     = w.button_turnout;
    case (w.action)
      ACT_PACKET: begin
        flash = run_command(w.packet_address, w.coil_index, w.turn_on);
      end
      ACT_BUTTON: begin
        if (w.turn_on) lever_pos[t] = ~lever_pos[t];
        flash = run_command(own_addr, {t, lever_pos[t]}, w.turn_on);
      end
      ACT_TICK: begin
        // Advance running pulses; drop the pair whose pulse expires
        for (int p = 0; p < NumPairs; p++) begin
          if (pulse_left[p] != '0) begin
            pulse_left[p] = pulse_left[p] - 1'b1;
            if (pulse_left[p] == '0) coil_lv[2*p +: 2] = 2'b00;
          end
        end
      end
      default: ;
    endcase
    r.output_levels = coil_lv;
    r.confirm_flash = flash;
    return r;
  endfunction

  function automatic tcpd_in_t mk_word(logic [1:0] act, logic [AddrW-1:0] addr,
                                       logic [CoilW-1:0] coil, logic on,
                                       logic [TurnoutW-1:0] turnout);
    tcpd_in_t w;
    w.action         = act;
    w.packet_address = addr;
    w.coil_index     = coil;
    w.turn_on        = on;
    w.button_turnout = turnout;
    return w;
  endfunction

  // Mostly commands to our own address, some broadcast, some foreign; also ticks and unused kinds
  function automatic tcpd_in_t random_word();
    tcpd_in_t w;
    int       pick;
    int       dest;
    w.packet_address = AddrW'($urandom_range(0, 511));
    w.coil_index     = CoilW'($urandom_range(0, 7));
    w.turn_on        = 1'($urandom_range(0, 1));
    w.button_turnout = TurnoutW'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    dest = $urandom_range(0, 9);
    if (pick < 40) begin
      w.action = ACT_PACKET;
      if (dest < 6) w.packet_address = own_addr;
      else if (dest < 8) w.packet_address = BroadcastAddr;
    end else if (pick < 60) begin
      w.action = ACT_BUTTON;
    end else if (pick < 95) begin
      w.action = ACT_TICK;
    end else begin
      w.action = ActUnused;
    end
    return w;
  endfunction

  function automatic logic [PulseW-1:0] random_pulse();
    case ($urandom_range(0, 3))
      0:       return '0;
      3:       return PulseW'($urandom_range(0, 255));
      default: return PulseW'($urandom_range(1, 6));
    endcase
  endfunction

  // Write one register and mirror it in the predictor
  task automatic write_reg(tcpd_cfg_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      CFG_OWN_ADDRESS:  own_addr     = val;
      CFG_PULSE_TIME_0: pulse_len[0] = val[PulseW-1:0];
      CFG_PULSE_TIME_1: pulse_len[1] = val[PulseW-1:0];
      CFG_PULSE_TIME_2: pulse_len[2] = val[PulseW-1:0];
      CFG_PULSE_TIME_3: pulse_len[3] = val[PulseW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [AddrW-1:0] addr, logic [PulseW-1:0] p0,
                            logic [PulseW-1:0] p1, logic [PulseW-1:0] p2,
                            logic [PulseW-1:0] p3);
    write_reg(CFG_OWN_ADDRESS, addr);
    write_reg(CFG_PULSE_TIME_0, CfgDataW'(p0));
    write_reg(CFG_PULSE_TIME_1, CfgDataW'(p1));
    write_reg(CFG_PULSE_TIME_2, CfgDataW'(p2));
    write_reg(CFG_PULSE_TIME_3, CfgDataW'(p3));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Block until every queued word is sent and every result has come back
  task automatic drain();
    while (cmd_backlog.size() != 0 || coil_report_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic note_mismatch(string field, int want, int got);
    fail_count++;
    if (fail_count <= ReportMax)
      $display("mismatch %s: expected %0h, got %0h", field, want, got);
  endtask

  // Drive input words: hold a stalled word, otherwise idle now and then
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !word_taken) begin
      // hold the stalled word
    end else if (send_gap != 0) begin
      in_valid_i <= 1'b0;
      send_gap--;
    end else if (cmd_backlog.size() == 0) begin
      in_valid_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      send_gap = $urandom_range(0, 3);
    end else begin
      in_valid_i <= 1'b1;
      in_word_i  <= cmd_backlog[0];
    end
  end

  // Stall the result side in short random bursts
  always @(negedge clk_i) begin
    if (calm) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Predict on each accepted input word
  always @(posedge clk_i) begin
    word_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      coil_report_due.push_back(drive_coils(in_word_i));
      cmd_backlog.delete(0);
    end
  end

  // Check each accepted result word against the oldest prediction
  always @(posedge clk_i) begin
    tcpd_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (coil_report_due.size() == 0) begin
        fail_count++;
        if (fail_count <= ReportMax)
          $display("unexpected result word %0h", out_word_o);
      end else begin
        want = coil_report_due.pop_front();
        if (out_word_o.output_levels !== want.output_levels)
          note_mismatch("output_levels", int'(want.output_levels),
                        int'(out_word_o.output_levels));
        if (out_word_o.confirm_flash !== want.confirm_flash)
          note_mismatch("confirm_flash", int'(want.confirm_flash),
                        int'(out_word_o.confirm_flash));
      end
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [AddrW-1:0] a;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_word_i    = '0;
    out_stall_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    word_taken   = 1'b0;
    calm         = 1'b0;
    send_gap     = 0;
    stall_left   = 0;
    quiet_cycles = 0;
    fail_count   = 0;
    own_addr     = '0;
    coil_lv      = '0;
    for (int p = 0; p < NumPairs; p++) begin
      pulse_len[p]  = '0;
      pulse_left[p] = '0;
      lever_pos[p]  = 1'b0;
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: on/off with and without auto-off, foreign and broadcast, stop, buttons
    set_config(9'd5, 8'd0, 8'd3, 8'd255, 8'd1);
    a = 9'd5;
    cmd_backlog.push_back(mk_word(ACT_PACKET, a, 3'd0, 1'b1, 2'd0));
    cmd_backlog.push_back(mk_word(ACT_PACKET, a, 3'd1, 1'b1, 2'd3));
    cmd_backlog.push_back(mk_word(ACT_PACKET, a, 3'd1, 1'b0, 2'd0));
    cmd_backlog.push_back(mk_word(ACT_PACKET, a, 3'd2, 1'b1, 2'd0));
    cmd_backlog.push_back(mk_word(ACT_PACKET, a, 3'd2, 1'b0, 2'd0));
    cmd_backlog.push_back(mk_word(ACT_PACKET, 9'd0, 3'd7, 1'b1, 2'd0));
    cmd_backlog.push_back(mk_word(ACT_PACKET, 9'd510, 3'd6, 1'b1, 2'd0));
    cmd_backlog.push_back(mk_word(ACT_PACKET, a, 3'd4, 1'b1, 2'd0));
    cmd_backlog.push_back(mk_word(ACT_PACKET, a, 3'd7, 1'b1, 2'd0));
    cmd_backlog.push_back(mk_word(ACT_TICK, 9'd0, 3'd0, 1'b0, 2'd0));
    cmd_backlog.push_back(mk_word(ACT_TICK, 9'd511, 3'd7, 1'b1, 2'd3));
    cmd_backlog.push_back(mk_word(ACT_TICK, 9'd0, 3'd0, 1'b0, 2'd0));
    cmd_backlog.push_back(mk_word(ACT_PACKET, BroadcastAddr, 3'd5, 1'b1, 2'd0));
    cmd_backlog.push_back(mk_word(ACT_PACKET, BroadcastAddr, EstopCoil, 1'b0, 2'd0));
    cmd_backlog.push_back(mk_word(ACT_BUTTON, 9'd0, 3'd0, 1'b1, 2'd0));
    cmd_backlog.push_back(mk_word(ACT_BUTTON, 9'd0, 3'd0, 1'b0, 2'd0));
    cmd_backlog.push_back(mk_word(ACT_BUTTON, 9'd511, 3'd7, 1'b1, 2'd1));
    cmd_backlog.push_back(mk_word(ACT_BUTTON, 9'd0, 3'd0, 1'b1, 2'd1));
    cmd_backlog.push_back(mk_word(ACT_BUTTON, 9'd0, 3'd0, 1'b1, 2'd3));
    cmd_backlog.push_back(mk_word(ActUnused, 9'd511, 3'd7, 1'b1, 2'd3));
    cmd_backlog.push_back(mk_word(ACT_PACKET, BroadcastAddr, EstopCoil, 1'b1, 2'd0));
    drain();

    // Own address just below broadcast: a button toggle drives coil 3, the stop coil only at broadcast
    set_config(9'd510, 8'd2, 8'd0, 8'd0, 8'd0);
    cmd_backlog.push_back(mk_word(ACT_PACKET, 9'd510, 3'd3, 1'b1, 2'd0));
    cmd_backlog.push_back(mk_word(ACT_BUTTON, 9'd0, 3'd0, 1'b1, 2'd1));
    cmd_backlog.push_back(mk_word(ACT_TICK, 9'd0, 3'd0, 1'b0, 2'd0));
    drain();

    // Random phases: extremes first, then mixed settings, the last without idling
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       set_config(9'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        1:       set_config(9'd510, 8'd255, 8'd255, 8'd255, 8'd255);
        default: set_config(AddrW'($urandom_range(0, 510)), random_pulse(), random_pulse(),
                            random_pulse(), random_pulse());
      endcase
      calm = (ph == 5);
      for (int n = 0; n < 200; n++) cmd_backlog.push_back(random_word());
      drain();
    end

    repeat (10) @(posedge clk_i);
    fail_count += coil_report_due.size();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/tcpd_pkg.sv
src/tcpd_skid.sv
src/turnout_coil_pulse_driver.sv
test/tb_turnout_coil_pulse_driver.sv
